/* sv/hale_pkg.sv */
`default_nettype none

package hale_pkg;

    // Phase of the line being parsed.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_ADDR  = 3'd2,
        PH_ATAIL = 3'd3,
        PH_FIRST = 3'd4,
        PH_COMP  = 3'd5,
        PH_JUMP  = 3'd6,
        PH_CTAIL = 3'd7
    } t_phase;

    // Error codes carried with each result word.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_MNEM = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned  TOKEN_DEPTH    = 3;
    localparam logic [2:0]   TOKEN_TOO_LONG = 3'd4;
    localparam logic [18:0]  ADDR_LIMIT     = 19'd32767;
    localparam logic [2:0]   C_PREFIX       = 3'b111;

    localparam int unsigned  DATA_IN_W  = 8;
    localparam int unsigned  DATA_OUT_W = 24;

    // Current mnemonic: up to three bytes and its length.
    typedef struct packed {
        logic [2:0]      len;
        logic [2:0][7:0] chars;
    } t_token;

    // Decoded mnemonic lookups on the current token.
    typedef struct packed {
        logic       comp_hit;
        logic [6:0] comp_code;
        logic       dest_hit;
        logic [2:0] dest_code;
        logic       jump_hit;
        logic [2:0] jump_code;
    } t_mnem_dec;

    // One finished line.
    typedef struct packed {
        logic        valid;
        logic [15:0] word;
        logic [1:0]  err;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

/* sv/hale_mnem_dec.sv */
`default_nettype none

module hale_mnem_dec
    import hale_pkg::*;
(
    input  wire t_token    i_token,
    output t_mnem_dec      o_dec
);

    logic [26:0] w_key;

    // Length in the key keeps a short token with zero bytes apart from a longer one.
    assign w_key = {i_token.len, i_token.chars[0], i_token.chars[1], i_token.chars[2]};

    always_comb begin
        o_dec.comp_hit  = 1'b1;
        o_dec.comp_code = 7'h00;
        o_dec.dest_hit  = 1'b1;
        o_dec.dest_code = 3'd0;
        o_dec.jump_hit  = 1'b1;
        o_dec.jump_code = 3'd0;

        // Comp mnemonics, a-bit on top.
        case (w_key)
            {3'd1, "0",   16'h0}: o_dec.comp_code = 7'h2A;
            {3'd1, "1",   16'h0}: o_dec.comp_code = 7'h3F;
            {3'd2, "-1",  8'h0}:  o_dec.comp_code = 7'h3A;
            {3'd1, "D",   16'h0}: o_dec.comp_code = 7'h0C;
            {3'd1, "A",   16'h0}: o_dec.comp_code = 7'h30;
            {3'd2, "!D",  8'h0}:  o_dec.comp_code = 7'h0D;
            {3'd2, "!A",  8'h0}:  o_dec.comp_code = 7'h31;
            {3'd2, "-D",  8'h0}:  o_dec.comp_code = 7'h0F;
            {3'd2, "-A",  8'h0}:  o_dec.comp_code = 7'h33;
            {3'd3, "D+1"}:        o_dec.comp_code = 7'h1F;
            {3'd3, "A+1"}:        o_dec.comp_code = 7'h37;
            {3'd3, "D-1"}:        o_dec.comp_code = 7'h0E;
            {3'd3, "A-1"}:        o_dec.comp_code = 7'h32;
            {3'd3, "D+A"}:        o_dec.comp_code = 7'h02;
            {3'd3, "D-A"}:        o_dec.comp_code = 7'h13;
            {3'd3, "A-D"}:        o_dec.comp_code = 7'h07;
            {3'd3, "D&A"}:        o_dec.comp_code = 7'h00;
            {3'd3, "D|A"}:        o_dec.comp_code = 7'h15;
            {3'd1, "M",   16'h0}: o_dec.comp_code = 7'h70;
            {3'd2, "!M",  8'h0}:  o_dec.comp_code = 7'h71;
            {3'd2, "-M",  8'h0}:  o_dec.comp_code = 7'h73;
            {3'd3, "M+1"}:        o_dec.comp_code = 7'h77;
            {3'd3, "M-1"}:        o_dec.comp_code = 7'h72;
            {3'd3, "D+M"}:        o_dec.comp_code = 7'h42;
            {3'd3, "D-M"}:        o_dec.comp_code = 7'h53;
            {3'd3, "M-D"}:        o_dec.comp_code = 7'h47;
            {3'd3, "D&M"}:        o_dec.comp_code = 7'h40;
            {3'd3, "D|M"}:        o_dec.comp_code = 7'h55;
            default:              o_dec.comp_hit  = 1'b0;
        endcase

        // Dest mnemonics; the empty one never matches.
        case (w_key)
            {3'd1, "M",   16'h0}: o_dec.dest_code = 3'd1;
            {3'd1, "D",   16'h0}: o_dec.dest_code = 3'd2;
            {3'd2, "MD",  8'h0}:  o_dec.dest_code = 3'd3;
            {3'd1, "A",   16'h0}: o_dec.dest_code = 3'd4;
            {3'd2, "AM",  8'h0}:  o_dec.dest_code = 3'd5;
            {3'd2, "AD",  8'h0}:  o_dec.dest_code = 3'd6;
            {3'd3, "AMD"}:        o_dec.dest_code = 3'd7;
            default:              o_dec.dest_hit  = 1'b0;
        endcase

        // Jump mnemonics.
        case (w_key)
            {3'd3, "JGT"}: o_dec.jump_code = 3'd1;
            {3'd3, "JEQ"}: o_dec.jump_code = 3'd2;
            {3'd3, "JGE"}: o_dec.jump_code = 3'd3;
            {3'd3, "JLT"}: o_dec.jump_code = 3'd4;
            {3'd3, "JNE"}: o_dec.jump_code = 3'd5;
            {3'd3, "JLE"}: o_dec.jump_code = 3'd6;
            {3'd3, "JMP"}: o_dec.jump_code = 3'd7;
            default:       o_dec.jump_hit  = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/hale_line_parser.sv */
`default_nettype none

module hale_line_parser
    import hale_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire [7:0]  i_char,
    output t_result    o_result
);

    t_phase      r_phase,    n_phase;
    logic [14:0] r_acc,      n_acc;
    logic        r_addr_bad, n_addr_bad;
    t_token      r_token,    n_token;
    logic [2:0]  r_dest,     n_dest;
    logic [6:0]  r_comp,     n_comp;
    logic        r_mnem_bad, n_mnem_bad;

    t_mnem_dec   w_dec;
    t_phase      w_work;
    logic        w_lead_done;
    logic [18:0] w_addr_next;
    logic [2:0]  w_jump;
    logic [6:0]  w_comp;
    logic        w_bad;

    hale_mnem_dec u_mnem_dec (
        .i_token (r_token),
        .o_dec   (w_dec)
    );

    assign w_addr_next = 19'(r_acc) * 19'd10 + 19'(i_char - CH_ZERO);

    // Next state and the result of the word in hand.
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_addr_bad  = r_addr_bad;
        n_token     = r_token;
        n_dest      = r_dest;
        n_comp      = r_comp;
        n_mnem_bad  = r_mnem_bad;
        o_result    = '0;
        w_work      = r_phase;
        w_lead_done = 1'b0;
        w_jump      = 3'd0;
        w_comp      = r_comp;
        w_bad       = r_mnem_bad;

        if (i_char == CH_NL) begin
            // End of line: encode, then start a fresh line.
            case (r_phase)
                PH_ADDR, PH_ATAIL: begin
                    w_bad          = r_addr_bad || (r_token.len == 3'd0);
                    o_result.valid = 1'b1;
                    o_result.word  = w_bad ? 16'h0000 : {1'b0, r_acc};
                    o_result.err   = w_bad ? ERR_ADDR : ERR_OK;
                end
                PH_FIRST, PH_COMP, PH_JUMP, PH_CTAIL: begin
                    if (r_phase == PH_FIRST || r_phase == PH_COMP) begin
                        w_comp = w_dec.comp_hit ? w_dec.comp_code : 7'h00;
                        w_bad  = r_mnem_bad || !w_dec.comp_hit;
                    end else if (r_phase == PH_JUMP || r_token.len != 3'd0) begin
                        w_jump = w_dec.jump_hit ? w_dec.jump_code : 3'd0;
                        w_bad  = r_mnem_bad || !w_dec.jump_hit;
                    end
                    o_result.valid = 1'b1;
                    o_result.word  = {C_PREFIX, w_comp, r_dest, w_jump};
                    o_result.err   = w_bad ? ERR_MNEM : ERR_OK;
                end
                default: o_result.valid = 1'b0;
            endcase
            n_phase    = PH_LEAD;
            n_acc      = '0;
            n_addr_bad = 1'b0;
            n_token    = '0;
            n_dest     = '0;
            n_comp     = '0;
            n_mnem_bad = 1'b0;
        end else begin
            // Start of line decides the kind of line.
            if (r_phase == PH_LEAD) begin
                w_lead_done = 1'b1;
                if (is_blank(i_char)) begin
                    n_phase = PH_LEAD;
                end else if (i_char == CH_SLASH) begin
                    n_phase = PH_SKIP;
                end else if (i_char == CH_AT) begin
                    n_phase = PH_ADDR;
                end else begin
                    w_work      = PH_FIRST;
                    n_phase     = PH_FIRST;
                    w_lead_done = 1'b0;
                end
            end

            if (!w_lead_done && !is_blank(i_char)) begin
                case (w_work)
                    PH_ADDR: begin
                        if (i_char == CH_SLASH) begin
                            n_phase = PH_ATAIL;
                        end else if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
                            n_token.len = 3'd1;
                            if (!r_addr_bad) begin
                                if (w_addr_next > ADDR_LIMIT) begin
                                    n_addr_bad = 1'b1;
                                    n_acc      = '0;
                                end else begin
                                    n_acc = w_addr_next[14:0];
                                end
                            end
                        end else begin
                            n_addr_bad = 1'b1;
                        end
                    end
                    PH_FIRST, PH_COMP, PH_JUMP: begin
                        if (i_char == CH_EQ && w_work == PH_FIRST) begin
                            n_dest     = w_dec.dest_hit ? w_dec.dest_code : 3'd0;
                            n_mnem_bad = r_mnem_bad || !w_dec.dest_hit;
                            n_token    = '0;
                            n_phase    = PH_COMP;
                        end else if (i_char == CH_SEMI && w_work != PH_JUMP) begin
                            n_comp     = w_dec.comp_hit ? w_dec.comp_code : 7'h00;
                            n_mnem_bad = r_mnem_bad || !w_dec.comp_hit;
                            n_token    = '0;
                            n_phase    = PH_JUMP;
                        end else if (i_char == CH_SLASH && w_work != PH_JUMP) begin
                            n_comp     = w_dec.comp_hit ? w_dec.comp_code : 7'h00;
                            n_mnem_bad = r_mnem_bad || !w_dec.comp_hit;
                            n_token    = '0;
                            n_phase    = PH_CTAIL;
                        end else if (i_char == CH_SLASH) begin
                            // A jump part cut short by a comment keeps its token.
                            n_mnem_bad = r_mnem_bad || (r_token.len == 3'd0);
                            n_phase    = PH_CTAIL;
                        end else if (r_token.len < 3'(TOKEN_DEPTH)) begin
                            n_token.chars[r_token.len[1:0]] = i_char;
                            n_token.len                     = r_token.len + 3'd1;
                        end else begin
                            n_token.len = TOKEN_TOO_LONG;
                        end
                    end
                    default: n_phase = n_phase;
                endcase
            end
        end
    end

    // Line state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_acc      <= '0;
            r_addr_bad <= 1'b0;
            r_token    <= '0;
            r_dest     <= '0;
            r_comp     <= '0;
            r_mnem_bad <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_addr_bad <= n_addr_bad;
            r_token    <= n_token;
            r_dest     <= n_dest;
            r_comp     <= n_comp;
            r_mnem_bad <= n_mnem_bad;
        end
    end

endmodule

`default_nettype wire

/* sv/hack_assembly_line_encoder_top.sv */
// Hack assembly line encoder.
// Text enters one byte per word on the slave stream (i_s_axis_*); each
// newline that closes an instruction line gives one word on the master
// stream (o_m_axis_*). Blank lines and comment lines give no word.
// A byte is captured in an input register, then decoded against the line
// state and, for a newline, the encoded instruction is loaded into the
// output register once that register is free; the result is then presented
// on the master stream.
// One byte is accepted every cycle unless a newline waits on a busy
// output register; the line state updates from the input register.
// When the receiver stalls with a word held, bytes that give no result
// still flow; a newline that closes a line waits in the input register,
// and the input then holds tready low until the output register frees.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a fresh line.
`default_nettype none

module hack_assembly_line_encoder_top
    import hale_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [DATA_IN_W-1:0]   i_s_axis_tdata,  // [7:0] character
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [DATA_OUT_W-1:0] o_m_axis_tdata   // [15:0] instruction_word, [17:16] error_code
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic [1:0]  r_out_err;

    t_result     w_result;
    logic        w_out_free;
    logic        w_consume;

    hale_line_parser u_line_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_consume),
        .i_char   (r_in_char),
        .o_result (w_result)
    );

    // Handshake: a held byte moves on unless it needs a busy output slot.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_consume       = r_in_valid && (!w_result.valid || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_result.valid) begin
            r_out_word <= w_result.word;
            r_out_err  <= w_result.err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(DATA_OUT_W - 18)'(0), r_out_err, r_out_word};

endmodule

`default_nettype wire

/* tb/sv/tb_hack_assembly_line_encoder_top.sv */
`default_nettype none

module tb_hack_assembly_line_encoder_top;
    import hale_pkg::*;

    // One encoded line as it leaves the block.
    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  err;
    } t_line_result;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_IN_W-1:0]  s_tdata  = '0;     // [7:0] character
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [DATA_OUT_W-1:0] m_tdata;           // [15:0] instruction_word, [17:16] error_code

    int           src_idle_pct  = 0;
    int           snk_idle_pct  = 0;
    int           hold_left     = 0;
    int           chars_sent    = 0;
    int           mismatch_count = 0;
    t_line_result pending_words [$];
    logic [7:0]   line_buf [$];

    // Mnemonic tables of the Hack instruction set.
    string comp_text [28] = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A",
                              "D+1", "A+1", "D-1", "A-1", "D+A", "D-A", "A-D",
                              "D&A", "D|A", "M", "!M", "-M", "M+1", "M-1", "D+M",
                              "D-M", "M-D", "D&M", "D|M"};
    logic [6:0] comp_code [28] = '{7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31,
                                   7'h0F, 7'h33, 7'h1F, 7'h37, 7'h0E, 7'h32, 7'h02,
                                   7'h13, 7'h07, 7'h00, 7'h15, 7'h70, 7'h71, 7'h73,
                                   7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40, 7'h55};
    string dest_text [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
    string jump_text [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
    // Mnemonics that match no table entry, some of them separators.
    string odd_text [6] = '{"", "X", "DM", "AMDM", "=", ";"};

    hack_assembly_line_encoder_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Line encoder prediction: state of the line being parsed.
    // ------------------------------------------------------------------
    t_phase     parse_phase;
    logic [14:0] addr_value;
    logic        addr_invalid;
    logic [7:0]  tok_byte [3];
    logic [2:0]  tok_len;
    logic [2:0]  dest_field;
    logic [6:0]  comp_field;
    logic        mnem_invalid;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void clear_token();
        tok_byte[0] = 8'h00;
        tok_byte[1] = 8'h00;
        tok_byte[2] = 8'h00;
        tok_len     = 3'd0;
    endfunction

    function automatic void reset_line();
        parse_phase  = PH_LEAD;
        addr_value   = '0;
        addr_invalid = 1'b0;
        dest_field   = '0;
        comp_field   = '0;
        mnem_invalid = 1'b0;
        clear_token();
    endfunction

    function automatic logic token_equals(input string s);
        int n;
        n = s.len();
        if (n == 0 || n > TOKEN_DEPTH || n != tok_len)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (tok_byte[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        if (tok_len < TOKEN_DEPTH) begin
            tok_byte[tok_len] = c;
            tok_len = tok_len + 3'd1;
        end else begin
            tok_len = TOKEN_TOO_LONG;
        end
    endfunction

    function automatic logic [6:0] lookup_comp();
        for (int i = 0; i < 28; i++)
            if (token_equals(comp_text[i]))
                return comp_code[i];
        mnem_invalid = 1'b1;
        return 7'd0;
    endfunction

    // Dest and jump share the shape: index 1..7 is the code, empty never matches.
    function automatic logic [2:0] lookup_field(input logic is_jump);
        for (int i = 1; i < 8; i++)
            if (token_equals(is_jump ? jump_text[i] : dest_text[i]))
                return 3'(i);
        mnem_invalid = 1'b1;
        return 3'd0;
    endfunction

    // At a newline: queue the word the finished line should give, if any.
    function automatic void close_line();
        t_line_result r;
        logic [2:0]   jmp;
        logic         emit;
        jmp  = 3'd0;
        emit = 1'b1;
        if (parse_phase == PH_ADDR || parse_phase == PH_ATAIL) begin
            if (tok_len == 3'd0)
                addr_invalid = 1'b1;
            r.word = addr_invalid ? 16'h0000 : {1'b0, addr_value};
            r.err  = addr_invalid ? ERR_ADDR : ERR_OK;
        end else begin
            case (parse_phase)
                PH_FIRST, PH_COMP: comp_field = lookup_comp();
                PH_JUMP:           jmp = lookup_field(1'b1);
                PH_CTAIL:          if (tok_len != 3'd0) jmp = lookup_field(1'b1);
                default:           emit = 1'b0;
            endcase
            r.word = {C_PREFIX, comp_field, dest_field, jmp};
            r.err  = mnem_invalid ? ERR_MNEM : ERR_OK;
        end
        if (emit)
            pending_words.push_back(r);
        reset_line();
    endfunction

    // Advance the line state by one accepted character.
    function automatic void encode_char(input logic [7:0] c);
        int unsigned acc;
        if (c == CH_NL) begin
            close_line();
            return;
        end
        if (parse_phase == PH_LEAD) begin
            if (is_ws(c))
                return;
            if (c == CH_SLASH) begin
                parse_phase = PH_SKIP;
                return;
            end
            if (c == CH_AT) begin
                parse_phase = PH_ADDR;
                return;
            end
            parse_phase = PH_FIRST;
        end
        if (is_ws(c))
            return;
        case (parse_phase)
            PH_ADDR: begin
                if (c == CH_SLASH) begin
                    parse_phase = PH_ATAIL;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    tok_len = 3'd1;
                    if (!addr_invalid) begin
                        acc = addr_value * 10 + (c - CH_ZERO);
                        if (acc > ADDR_LIMIT) begin
                            addr_invalid = 1'b1;
                            addr_value   = '0;
                        end else begin
                            addr_value = acc[14:0];
                        end
                    end
                end else begin
                    addr_invalid = 1'b1;
                end
            end
            PH_FIRST, PH_COMP: begin
                if (c == CH_EQ && parse_phase == PH_FIRST) begin
                    dest_field = lookup_field(1'b0);
                    clear_token();
                    parse_phase = PH_COMP;
                end else if (c == CH_SEMI) begin
                    comp_field = lookup_comp();
                    clear_token();
                    parse_phase = PH_JUMP;
                end else if (c == CH_SLASH) begin
                    comp_field = lookup_comp();
                    clear_token();
                    parse_phase = PH_CTAIL;
                end else begin
                    push_byte(c);
                end
            end
            PH_JUMP: begin
                if (c == CH_SLASH) begin
                    if (tok_len == 3'd0)
                        mnem_invalid = 1'b1;
                    parse_phase = PH_CTAIL;
                end else begin
                    push_byte(c);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR at %0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Each word taken from the block is compared with the oldest prediction.
    always @(posedge clk) begin : check_words
        t_line_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with none expected", m_tdata[15:0], 16'h0000);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata[15:0] != want.word)
                    report_mismatch("instruction_word", m_tdata[15:0], want.word);
                if (m_tdata[17:16] != want.err)
                    report_mismatch("error_code", 16'(m_tdata[17:16]), 16'(want.err));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        encode_char(c);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Lower the valid and hold until every predicted word has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Line builders for the random part.
    // ------------------------------------------------------------------
    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_blanks();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
        repeat (n) begin
            case ($urandom_range(2))
                0:       line_buf.push_back(CH_SPACE);
                1:       line_buf.push_back(CH_TAB);
                default: line_buf.push_back(CH_CR);
            endcase
        end
    endfunction

    function automatic void build_c_line();
        put_blanks();
        if ($urandom_range(3) != 0) begin
            put_text(($urandom_range(9) == 0) ? odd_text[$urandom_range(5)]
                                              : dest_text[$urandom_range(7, 1)]);
            put_blanks();
            line_buf.push_back(CH_EQ);
            put_blanks();
        end
        put_text(($urandom_range(11) == 0) ? odd_text[$urandom_range(5)]
                                           : comp_text[$urandom_range(27)]);
        put_blanks();
        if ($urandom_range(1) == 1) begin
            line_buf.push_back(CH_SEMI);
            put_blanks();
            put_text(($urandom_range(9) == 0) ? odd_text[$urandom_range(5)]
                                              : jump_text[$urandom_range(7, 1)]);
            put_blanks();
        end
        if ($urandom_range(19) == 0)
            line_buf.push_back(8'($urandom_range(255)));
        if ($urandom_range(4) == 0)
            put_text("// note");
        line_buf.push_back(CH_NL);
    endfunction

    function automatic void build_addr_line();
        put_blanks();
        line_buf.push_back(CH_AT);
        put_blanks();
        case ($urandom_range(9))
            0:       ;
            1:       put_text($sformatf("%0d", $urandom_range(99999, 32768)));
            2:       put_text($sformatf("%05d", $urandom_range(999)));
            default: put_text($sformatf("%0d", $urandom_range(32767)));
        endcase
        put_blanks();
        if ($urandom_range(9) == 0)
            line_buf.push_back(8'($urandom_range(126, 33)));
        if ($urandom_range(4) == 0)
            put_text("//a");
        line_buf.push_back(CH_NL);
    endfunction

    function automatic void build_quiet_line();
        put_blanks();
        if ($urandom_range(1) == 1)
            put_text("// comment");
        line_buf.push_back(CH_NL);
    endfunction

    function automatic void build_noise_line();
        repeat ($urandom_range(6, 1))
            line_buf.push_back(8'($urandom_range(255)));
        line_buf.push_back(CH_NL);
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Address extremes, blank and comment lines, the widest C line, empty
    // parts, a trailing comment and the extreme byte values.
    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_text("@32767\n");
        send_text("@32768\n");
        send_text("@\n");
        send_text(" \t\r\n");
        send_text("//\n");
        send_text("AMD=D|M;JMP\n");
        send_text("=;\n");
        send_text("0;JMP/x\n");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_NL);
        wait_drained();
    endtask

    // Mostly well-formed lines with random content, the rest quiet or noise.
    task automatic test_random_lines(input int src_pct, input int snk_pct,
                                     input int n_chars);
        int stop_at;
        int pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45)
                build_c_line();
            else if (pick < 75)
                build_addr_line();
            else if (pick < 85)
                build_quiet_line();
            else
                build_noise_line();
            send_line();
        end
        wait_drained();
    endtask

    // The receiver holds off while lines keep coming, so the output word and
    // the waiting newline fill the block and its input stalls.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_left = 80;
        repeat (15) begin
            build_c_line();
            send_line();
        end
        wait_drained();
    endtask

    initial begin
        reset_line();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_lines(32, 79, 400);
        test_random_lines(79, 32, 400);
        test_backpressure();
        test_random_lines(0, 0, 400);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("hack_assembly_line_encoder_top: match");
        else
            $display("hack_assembly_line_encoder_top: mismatch");
        $finish;
    end

    // Overall time limit.
    initial begin
        #5000000;
        $display("hack_assembly_line_encoder_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
